@@ rtl/rdsg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsg_pkg
// Shared constants, message kinds and the result word of the group decoder.
// ----------------------------------------------------------------------------
package rdsg_pkg;

  localparam int PS_LEN   = 8;
  localparam int RT_A_LEN = 64;
  localparam int RT_B_LEN = 32;

  localparam logic [7:0] TEXT_END = 8'h0D;

  // message kinds on tuser
  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_PTY    = 3'd1;
  localparam logic [2:0] KIND_TA     = 3'd2;
  localparam logic [2:0] KIND_PS     = 3'd3;
  localparam logic [2:0] KIND_TEXT_A = 3'd4;
  localparam logic [2:0] KIND_TEXT_B = 3'd5;

  // group types handled
  localparam logic [3:0] GRP_BASIC   = 4'd0;
  localparam logic [3:0] GRP_TEXT    = 4'd2;
  localparam logic [3:0] GRP_EON     = 4'd14;
  localparam logic [3:0] GRP_FAST    = 4'd15;

  // memory sizes and layout
  localparam int WORK_DEPTH  = 256;
  localparam int SHOWN_DEPTH = 128;
  localparam int WORK_AW     = $clog2(WORK_DEPTH);
  localparam int SHOWN_AW    = $clog2(SHOWN_DEPTH);

  localparam logic [7:0] RTB_WBASE = 8'(2 * RT_A_LEN);
  localparam logic [7:0] PS_WBASE  = 8'(2 * RT_A_LEN + RT_B_LEN);
  localparam logic [6:0] RTA_SBASE = 7'd0;
  localparam logic [6:0] RTB_SBASE = 7'(RT_A_LEN);
  localparam logic [6:0] PS_SBASE  = 7'(RT_A_LEN + RT_B_LEN);

  localparam logic [5:0] RTA_LAST = 6'(RT_A_LEN - 1);
  localparam logic [4:0] RTB_LAST = 5'(RT_B_LEN - 1);

  localparam int OUT_DATA_W = 48;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  value;
    logic [5:0]  pos;
    logic [7:0]  first;
    logic [7:0]  second;
    logic [1:0]  count;
    logic        last;
    logic [15:0] pi;
    logic        tp;
    logic        ms;
    logic        ta;
  } rdsg_word_t;

endpackage

@@ rtl/rdsg_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsg_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rdsg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/rdsg_out.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsg_out
// Output register of the decoder: holds one result word and packs the stream.
// ----------------------------------------------------------------------------
module rdsg_out (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               load,
  input  rdsg_pkg::rdsg_word_t               word,
  input  logic                               m_tready,
  output logic                               m_tvalid,
  output logic [rdsg_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic [2:0]                         m_tuser,
  output logic                               m_tlast,
  output logic                               free
);

  rdsg_pkg::rdsg_word_t held;

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (load) begin
      held <= word;
    end
  end

  assign m_tdata = {held.ta, held.ms, held.tp, held.pi, held.count,
                    held.second, held.first, held.pos, held.value};
  assign m_tuser = held.kind;
  assign m_tlast = held.last;

endmodule

@@ rtl/rds_group_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rds_group_decoder
// RDS group decoder: PI/PTY/TP/MS/TA tracking, PS name and RadioText assembly.
// ----------------------------------------------------------------------------
// One group is taken at a time. A segment write stores its characters in the
// work memory, a text end compares the work copy against the shown copy (one
// character per cycle through the single read port of each memory), and
// changed text is copied to the shown copy and sent in words of up to two
// characters. After reset a clearing pass zeroes both memories before the
// first group is accepted.
module rds_group_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // block_a, block_b, block_c, block_d
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // msg_value, char_pos, char_first, char_second,
                                 // char_count, prog_ident, traffic_program,
                                 // music_speech, traffic_announce
  output logic [2:0]  m_tuser,   // msg_kind
  output logic        m_tlast    // last
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_WR, S_CMP, S_DISP, S_PTY, S_TA, S_TXA, S_TXB, S_TXC, S_TXD
  } state_t;

  state_t state;

  logic [rdsg_pkg::WORK_AW-1:0]  clr_cnt;
  logic [15:0] pi_code;
  logic [4:0]  pty_code;
  logic        tp_flag, ms_flag, ta_active;
  logic [2:0]  ps_seq;
  logic [4:0]  rt_seq;
  logic        pty_pend, ta_pend, txt_pend;
  logic [7:0]  ch [4];
  logic [2:0]  nchar, wcnt;
  logic [7:0]  waddr0, wbase;
  logic [6:0]  sbase;
  logic        do_cmp;
  logic [6:0]  len, ccnt, tpos;
  logic        rv, diff;
  logic [2:0]  tkind;
  logic [7:0]  c1, c2;

  // accept-time decode
  logic [15:0] bb, cc, dd;
  logic [3:0]  grp;
  logic        ver;
  logic [4:0]  pty_in;
  logic [2:0]  dec_nchar;
  logic        dec_cmp, dec_ta_upd, dec_ta_val;
  logic [6:0]  dec_len;
  logic [7:0]  dec_waddr, dec_wbase;
  logic [6:0]  dec_sbase;
  logic [2:0]  dec_kind;
  logic [2:0]  ps_seq_n;
  logic [4:0]  rt_seq_n;
  logic [7:0]  dec_ch [4];
  logic [5:0]  pos_a;
  logic [4:0]  pos_b;

  always_comb begin
    bb = s_tdata[31:16];
    cc = s_tdata[47:32];
    dd = s_tdata[63:48];
    grp = bb[15:12];
    ver = bb[11];
    pty_in = bb[9:5];
    dec_nchar = 3'd0;
    dec_cmp = 1'b0;
    dec_len = 7'd0;
    dec_waddr = 8'd0;
    dec_wbase = 8'd0;
    dec_sbase = 7'd0;
    dec_kind = rdsg_pkg::KIND_NONE;
    dec_ta_upd = 1'b0;
    dec_ta_val = 1'b0;
    ps_seq_n = ps_seq;
    rt_seq_n = rt_seq;
    pos_a = 6'd0;
    pos_b = 5'd0;
    dec_ch[0] = dd[15:8];
    dec_ch[1] = dd[7:0];
    dec_ch[2] = 8'd0;
    dec_ch[3] = 8'd0;
    if (grp == rdsg_pkg::GRP_BASIC) begin
      if (bb[1:0] == 2'd0 || ps_seq == {1'b0, bb[1:0]}) begin
        dec_ta_upd = 1'b1;
        dec_ta_val = bb[4] & bb[10];
        dec_nchar = 3'd2;
        dec_wbase = rdsg_pkg::PS_WBASE + {4'd0, ver, 3'd0};
        dec_waddr = dec_wbase + {5'd0, bb[1:0], 1'b0};
        dec_sbase = rdsg_pkg::PS_SBASE;
        dec_cmp = (bb[1:0] == 2'd3);
        dec_len = 7'(rdsg_pkg::PS_LEN);
        dec_kind = rdsg_pkg::KIND_PS;
        ps_seq_n = {1'b0, bb[1:0]} + 3'd1;
      end
    end else if (grp == rdsg_pkg::GRP_TEXT) begin
      if (bb[3:0] == 4'd0 || rt_seq == {1'b0, bb[3:0]}) begin
        rt_seq_n = {1'b0, bb[3:0]} + 5'd1;
        if (!ver) begin
          dec_nchar = 3'd4;
          dec_ch[0] = cc[15:8];
          dec_ch[1] = cc[7:0];
          dec_ch[2] = dd[15:8];
          dec_ch[3] = dd[7:0];
          dec_wbase = {1'b0, bb[4], 6'd0};
          dec_waddr = {1'b0, bb[4], bb[3:0], 2'd0};
          dec_sbase = rdsg_pkg::RTA_SBASE;
          dec_kind = rdsg_pkg::KIND_TEXT_A;
          for (int i = 0; i < 4; i++) begin
            pos_a = {bb[3:0], 2'(i)};
            if (!dec_cmp && (dec_ch[i] == rdsg_pkg::TEXT_END ||
                             pos_a == rdsg_pkg::RTA_LAST)) begin
              dec_cmp = 1'b1;
              dec_len = {1'b0, pos_a} + 7'd1;
            end
          end
        end else begin
          dec_nchar = 3'd2;
          dec_wbase = rdsg_pkg::RTB_WBASE;
          dec_waddr = rdsg_pkg::RTB_WBASE + {3'd0, bb[3:0], 1'b0};
          dec_sbase = rdsg_pkg::RTB_SBASE;
          dec_kind = rdsg_pkg::KIND_TEXT_B;
          for (int i = 0; i < 2; i++) begin
            pos_b = {bb[3:0], 1'(i)};
            if (!dec_cmp && (dec_ch[i] == rdsg_pkg::TEXT_END ||
                             pos_b == rdsg_pkg::RTB_LAST)) begin
              dec_cmp = 1'b1;
              dec_len = {2'd0, pos_b} + 7'd1;
            end
          end
        end
      end
    end else if (grp == rdsg_pkg::GRP_EON && ver) begin
      dec_ta_upd = 1'b1;
      dec_ta_val = (bb[4:3] == 2'b11);
    end
  end

  // memories
  logic                          work_we, shown_we;
  logic [rdsg_pkg::WORK_AW-1:0]  work_waddr, work_raddr;
  logic [rdsg_pkg::SHOWN_AW-1:0] shown_waddr, shown_raddr;
  logic [7:0]                    work_wdata, shown_wdata, work_rdata, shown_rdata;
  logic                          two_chars;

  assign two_chars = ({1'b0, tpos} + 8'd1) < {1'b0, len};

  always_comb begin
    work_we = 1'b0;
    work_waddr = waddr0 + {5'd0, wcnt};
    work_wdata = ch[wcnt[1:0]];
    work_raddr = 8'd0;
    shown_we = 1'b0;
    shown_waddr = sbase + tpos;
    shown_wdata = work_rdata;
    shown_raddr = sbase + ccnt;
    unique case (state)
      S_CLR: begin
        work_we = 1'b1;
        work_waddr = clr_cnt;
        work_wdata = 8'd0;
        shown_we = 1'b1;
        shown_waddr = clr_cnt[rdsg_pkg::SHOWN_AW-1:0];
        shown_wdata = 8'd0;
      end
      S_WR:  work_we = 1'b1;
      S_CMP: work_raddr = wbase + {1'b0, ccnt};
      S_TXA: work_raddr = wbase + {1'b0, tpos};
      S_TXB: begin
        shown_we = 1'b1;
        work_raddr = wbase + {1'b0, tpos} + 8'd1;
      end
      S_TXC: begin
        shown_we = two_chars;
        shown_waddr = sbase + tpos + 7'd1;
      end
      default: ;
    endcase
  end

  rdsg_ram #(.WIDTH(8), .DEPTH(rdsg_pkg::WORK_DEPTH)) u_work (
    .clk(clk), .we(work_we), .waddr(work_waddr), .wdata(work_wdata),
    .raddr(work_raddr), .rdata(work_rdata)
  );

  rdsg_ram #(.WIDTH(8), .DEPTH(rdsg_pkg::SHOWN_DEPTH)) u_shown (
    .clk(clk), .we(shown_we), .waddr(shown_waddr), .wdata(shown_wdata),
    .raddr(shown_raddr), .rdata(shown_rdata)
  );

  // output word
  rdsg_pkg::rdsg_word_t word;
  logic out_load, out_free;
  logic txt_done;

  assign txt_done = ({1'b0, tpos} + 8'd2) >= {1'b0, len};

  always_comb begin
    word = '0;
    word.pi = pi_code;
    word.tp = tp_flag;
    word.ms = ms_flag;
    word.ta = ta_active;
    out_load = 1'b0;
    unique case (state)
      S_PTY: begin
        out_load = out_free;
        word.kind = rdsg_pkg::KIND_PTY;
        word.value = pty_code;
        word.last = !ta_pend && !txt_pend;
      end
      S_TA: begin
        out_load = out_free;
        word.kind = rdsg_pkg::KIND_TA;
        word.value = {4'd0, ta_active};
        word.last = !txt_pend;
      end
      S_TXD: begin
        out_load = out_free;
        word.kind = tkind;
        word.pos = tpos[5:0];
        word.first = c1;
        word.second = c2;
        word.count = two_chars ? 2'd2 : 2'd1;
        word.last = txt_done;
      end
      default: ;
    endcase
  end

  rdsg_out u_out (
    .clk(clk), .rst(rst), .load(out_load), .word(word), .m_tready(m_tready),
    .m_tvalid(m_tvalid), .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast),
    .free(out_free)
  );

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_cnt <= '0;
      pi_code <= 16'd0;
      pty_code <= 5'd0;
      tp_flag <= 1'b0;
      ms_flag <= 1'b0;
      ta_active <= 1'b0;
      ps_seq <= 3'd0;
      rt_seq <= 5'd0;
      pty_pend <= 1'b0;
      ta_pend <= 1'b0;
      txt_pend <= 1'b0;
      wcnt <= 3'd0;
      ccnt <= 7'd0;
      rv <= 1'b0;
      diff <= 1'b0;
      tpos <= 7'd0;
    end else begin
      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (&clr_cnt) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            pi_code <= s_tdata[15:0];
            pty_code <= pty_in;
            pty_pend <= (pty_in != pty_code);
            tp_flag <= bb[10];
            if (grp == rdsg_pkg::GRP_BASIC || (grp == rdsg_pkg::GRP_FAST && ver)) begin
              ms_flag <= bb[3];
            end
            ta_pend <= dec_ta_upd && (dec_ta_val != ta_active);
            if (dec_ta_upd) begin
              ta_active <= dec_ta_val;
            end
            ps_seq <= ps_seq_n;
            rt_seq <= rt_seq_n;
            txt_pend <= 1'b0;
            for (int i = 0; i < 4; i++) begin
              ch[i] <= dec_ch[i];
            end
            nchar <= dec_nchar;
            waddr0 <= dec_waddr;
            wbase <= dec_wbase;
            sbase <= dec_sbase;
            do_cmp <= dec_cmp;
            len <= dec_len;
            tkind <= dec_kind;
            wcnt <= 3'd0;
            state <= (dec_nchar != 3'd0) ? S_WR : S_DISP;
          end
        end
        S_WR: begin
          wcnt <= wcnt + 3'd1;
          if (wcnt + 3'd1 == nchar) begin
            ccnt <= 7'd0;
            rv <= 1'b0;
            diff <= 1'b0;
            state <= do_cmp ? S_CMP : S_DISP;
          end
        end
        S_CMP: begin
          // read data arrives in the cycle after its address is issued
          if (ccnt < len) begin
            ccnt <= ccnt + 7'd1;
          end
          rv <= (ccnt < len);
          if (rv && work_rdata != shown_rdata) begin
            diff <= 1'b1;
          end
          if (ccnt == len && !rv) begin
            txt_pend <= diff;
            tpos <= 7'd0;
            state <= S_DISP;
          end
        end
        S_DISP: begin
          if (pty_pend) begin
            state <= S_PTY;
          end else if (ta_pend) begin
            state <= S_TA;
          end else if (txt_pend) begin
            state <= S_TXA;
          end else begin
            state <= S_IDLE;
          end
        end
        S_PTY: begin
          if (out_free) begin
            pty_pend <= 1'b0;
            state <= S_DISP;
          end
        end
        S_TA: begin
          if (out_free) begin
            ta_pend <= 1'b0;
            state <= S_DISP;
          end
        end
        S_TXA: state <= S_TXB;
        S_TXB: begin
          c1 <= work_rdata;
          state <= S_TXC;
        end
        S_TXC: begin
          c2 <= two_chars ? work_rdata : 8'd0;
          state <= S_TXD;
        end
        S_TXD: begin
          if (out_free) begin
            tpos <= tpos + 7'd2;
            if (txt_done) begin
              txt_pend <= 1'b0;
              state <= S_DISP;
            end else begin
              state <= S_TXA;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/rdsg_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsg_props
// Port-level checks of the group decoder result stream.
// ----------------------------------------------------------------------------
module rdsg_props (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  // no word right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled word changed");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser != rdsg_pkg::KIND_NONE)
    else $error("word without kind");

  // status messages carry no characters
  a_msg_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == rdsg_pkg::KIND_PTY || m_tuser == rdsg_pkg::KIND_TA)
      |-> m_tdata[28:27] == 2'd0 && m_tdata[10:5] == 6'd0)
    else $error("status message with characters");

  a_text_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == rdsg_pkg::KIND_PS || m_tuser == rdsg_pkg::KIND_TEXT_A
      || m_tuser == rdsg_pkg::KIND_TEXT_B) |-> m_tdata[28:27] != 2'd0
      && m_tdata[4:0] == 5'd0)
    else $error("text word without characters");

endmodule

bind rds_group_decoder rdsg_props u_rdsg_props (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid), .m_tready(m_tready),
  .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
);

@@ bench/rdsg_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsg_checker
// Watches both streams of the group decoder, predicts the message words of
// every accepted group and compares them in order with the words that leave.
// ----------------------------------------------------------------------------
module rdsg_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  input  logic [2:0]  m_tuser,
  input  logic        m_tlast,
  output int          errors,
  output int          pending
);

  logic [15:0] pi_code;
  logic [4:0]  pty_code;
  logic        tp_flag, ms_flag, ta_on;
  logic [2:0]  ps_seq;
  logic [4:0]  rt_seq;
  logic [7:0]  ps_work [2*rdsg_pkg::PS_LEN];
  logic [7:0]  ps_shown [rdsg_pkg::PS_LEN];
  logic [7:0]  rta_work [2*rdsg_pkg::RT_A_LEN];
  logic [7:0]  rta_shown [rdsg_pkg::RT_A_LEN];
  logic [7:0]  rtb_work [rdsg_pkg::RT_B_LEN];
  logic [7:0]  rtb_shown [rdsg_pkg::RT_B_LEN];

  rdsg_pkg::rdsg_word_t group_msgs[$];
  rdsg_pkg::rdsg_word_t expected_msgs[$];

  task automatic add_msg(logic [2:0] kind, logic [4:0] value, int pos,
                         logic [7:0] c1, logic [7:0] c2, logic [1:0] cnt);
    rdsg_pkg::rdsg_word_t w;
    w = '0;
    w.kind = kind;
    w.value = value;
    w.pos = 6'(pos);
    w.first = c1;
    w.second = c2;
    w.count = cnt;
    group_msgs.push_back(w);
  endtask

  task automatic add_text(logic [2:0] kind, int len);
    logic [7:0] c1, c2;
    for (int p = 0; p < len; p += 2) begin
      c1 = (kind == rdsg_pkg::KIND_PS) ? ps_shown[p] :
           (kind == rdsg_pkg::KIND_TEXT_A) ? rta_shown[p] : rtb_shown[p];
      if (p + 1 < len) begin
        c2 = (kind == rdsg_pkg::KIND_PS) ? ps_shown[p+1] :
             (kind == rdsg_pkg::KIND_TEXT_A) ? rta_shown[p+1] : rtb_shown[p+1];
        add_msg(kind, 5'd0, p, c1, c2, 2'd2);
      end else begin
        add_msg(kind, 5'd0, p, c1, 8'd0, 2'd1);
      end
    end
  endtask

  task automatic update_ta(logic on);
    if (on && !ta_on) begin
      ta_on = 1'b1;
      add_msg(rdsg_pkg::KIND_TA, 5'd1, 0, 8'd0, 8'd0, 2'd0);
    end else if (!on && ta_on) begin
      ta_on = 1'b0;
      add_msg(rdsg_pkg::KIND_TA, 5'd0, 0, 8'd0, 8'd0, 2'd0);
    end
  endtask

  task automatic decode_ps(logic [15:0] b, logic [15:0] d, logic ver);
    int seg, base;
    logic differs;
    seg = b[1:0];
    base = ver * rdsg_pkg::PS_LEN;
    if (seg == 0) ps_seq = 3'd0;
    else if (ps_seq != 3'(seg)) return;
    update_ta(b[4] && b[10]);
    ps_work[base + seg*2] = d[15:8];
    ps_work[base + seg*2 + 1] = d[7:0];
    if (seg == 3) begin
      differs = 1'b0;
      for (int i = 0; i < rdsg_pkg::PS_LEN; i++)
        if (ps_shown[i] != ps_work[base + i]) differs = 1'b1;
      if (differs) begin
        for (int i = 0; i < rdsg_pkg::PS_LEN; i++) ps_shown[i] = ps_work[base + i];
        add_text(rdsg_pkg::KIND_PS, rdsg_pkg::PS_LEN);
      end
    end
    ps_seq = ps_seq + 3'd1;
  endtask

  task automatic decode_text(logic [15:0] b, logic [15:0] c, logic [15:0] d,
                             logic ver);
    int seg, pos, base, len;
    logic done, differs;
    logic [7:0] ch [4];
    seg = b[3:0];
    done = 1'b0;
    if (seg == 0) rt_seq = 5'd0;
    else if (rt_seq != 5'(seg)) return;
    ch[0] = c[15:8];
    ch[1] = c[7:0];
    ch[2] = d[15:8];
    ch[3] = d[7:0];
    if (!ver) begin
      base = b[4] * rdsg_pkg::RT_A_LEN;
      for (int i = 0; i < 4; i++) begin
        pos = seg*4 + i;
        rta_work[base + pos] = ch[i];
        if (!done && (ch[i] == rdsg_pkg::TEXT_END || pos == rdsg_pkg::RT_A_LEN - 1)) begin
          done = 1'b1;
          len = pos + 1;
          differs = 1'b0;
          for (int k = 0; k < len; k++)
            if (rta_shown[k] != rta_work[base + k]) differs = 1'b1;
          if (differs) begin
            for (int k = 0; k < len; k++) rta_shown[k] = rta_work[base + k];
            add_text(rdsg_pkg::KIND_TEXT_A, len);
          end
        end
      end
    end else begin
      for (int i = 0; i < 2; i++) begin
        pos = seg*2 + i;
        rtb_work[pos] = ch[2 + i];
        if (!done && (ch[2 + i] == rdsg_pkg::TEXT_END ||
                      pos == rdsg_pkg::RT_B_LEN - 1)) begin
          done = 1'b1;
          len = pos + 1;
          differs = 1'b0;
          for (int k = 0; k < len; k++)
            if (rtb_shown[k] != rtb_work[k]) differs = 1'b1;
          if (differs) begin
            for (int k = 0; k < len; k++) rtb_shown[k] = rtb_work[k];
            add_text(rdsg_pkg::KIND_TEXT_B, len);
          end
        end
      end
    end
    rt_seq = rt_seq + 5'd1;
  endtask

  task automatic predict_group(logic [63:0] data);
    logic [15:0] a, b, c, d;
    logic [3:0] grp;
    logic ver;
    rdsg_pkg::rdsg_word_t w;
    a = data[15:0];
    b = data[31:16];
    c = data[47:32];
    d = data[63:48];
    grp = b[15:12];
    ver = b[11];
    group_msgs.delete();
    pi_code = a;
    if (pty_code != b[9:5]) begin
      pty_code = b[9:5];
      add_msg(rdsg_pkg::KIND_PTY, b[9:5], 0, 8'd0, 8'd0, 2'd0);
    end
    tp_flag = b[10];
    if (grp == rdsg_pkg::GRP_BASIC || (grp == rdsg_pkg::GRP_FAST && ver))
      ms_flag = b[3];
    if (grp == rdsg_pkg::GRP_BASIC) decode_ps(b, d, ver);
    else if (grp == rdsg_pkg::GRP_TEXT) decode_text(b, c, d, ver);
    else if (grp == rdsg_pkg::GRP_EON && ver) update_ta(b[4:3] == 2'b11);
    for (int k = 0; k < group_msgs.size(); k++) begin
      w = group_msgs[k];
      w.last = (k == group_msgs.size() - 1);
      w.pi = pi_code;
      w.tp = tp_flag;
      w.ms = ms_flag;
      w.ta = ta_on;
      expected_msgs.push_back(w);
    end
  endtask

  task automatic compare_word(rdsg_pkg::rdsg_word_t want, rdsg_pkg::rdsg_word_t got);
    if (want !== got) begin
      errors++;
      $display("%0t: mismatch kind %0d/%0d value %0d/%0d pos %0d/%0d chars %h %h/%h %h",
               $realtime, want.kind, got.kind, want.value, got.value,
               want.pos, got.pos, want.first, want.second, got.first, got.second);
      $display("%0t:   count %0d/%0d last %0d/%0d pi %h/%h tp %0d/%0d ms %0d/%0d ta %0d/%0d",
               $realtime, want.count, got.count, want.last, got.last,
               want.pi, got.pi, want.tp, got.tp, want.ms, got.ms, want.ta, got.ta);
    end
  endtask

  always @(posedge clk) begin
    rdsg_pkg::rdsg_word_t got;
    if (rst) begin
      pi_code = '0; pty_code = '0; tp_flag = 0; ms_flag = 0; ta_on = 0;
      ps_seq = '0; rt_seq = '0;
      foreach (ps_work[i]) ps_work[i] = '0;
      foreach (ps_shown[i]) ps_shown[i] = '0;
      foreach (rta_work[i]) rta_work[i] = '0;
      foreach (rta_shown[i]) rta_shown[i] = '0;
      foreach (rtb_work[i]) rtb_work[i] = '0;
      foreach (rtb_shown[i]) rtb_shown[i] = '0;
      expected_msgs.delete();
      errors = 0;
    end else begin
      if (s_tvalid && s_tready) predict_group(s_tdata);
      if (m_tvalid && m_tready) begin
        got.kind = m_tuser;
        got.value = m_tdata[4:0];
        got.pos = m_tdata[10:5];
        got.first = m_tdata[18:11];
        got.second = m_tdata[26:19];
        got.count = m_tdata[28:27];
        got.last = m_tlast;
        got.pi = m_tdata[44:29];
        got.tp = m_tdata[45];
        got.ms = m_tdata[46];
        got.ta = m_tdata[47];
        if (expected_msgs.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, actual kind %0d data %h",
                   $realtime, m_tuser, m_tdata);
        end else begin
          compare_word(expected_msgs.pop_front(), got);
        end
      end
    end
    pending = expected_msgs.size();
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds directed and random RDS groups (PS, RadioText A/B, TA, noise) to the
// group decoder with bursty input and stalling output; the checker compares.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 600000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;
  int          errors;
  int          pending;
  int          cycles = 0;
  int          burst_left;
  int          ready_mode = 0;
  int          mode_left = 0;
  logic [4:0]  cur_pty;

  rds_group_decoder u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  rdsg_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .errors(errors), .pending(pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: stretches of always ready, random and mostly stalled
  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode <= $urandom_range(0, 2);
      mode_left <= $urandom_range(5, 60);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= $urandom_range(0, 1);
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic send_group(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                            logic [15:0] d);
    s_tdata <= {d, c, b, a};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      burst_left = $urandom_range(0, 6);
    end
  endtask

  function automatic logic [15:0] block_b(logic [3:0] grp, logic ver, logic tp,
                                          logic [4:0] low);
    return {grp, ver, tp, cur_pty, low};
  endfunction

  function automatic logic [7:0] rand_char();
    case ($urandom_range(0, 9))
      0: return 8'($urandom);
      1: return rdsg_pkg::TEXT_END;
      default: return 8'($urandom_range(8'h20, 8'h7e));
    endcase
  endfunction

  task automatic random_ps();
    logic ver;
    logic [15:0] pi;
    ver = $urandom_range(0, 1);
    pi = 16'($urandom);
    for (int s = 0; s < 4; s++)
      send_group(pi, block_b(rdsg_pkg::GRP_BASIC, ver, 1'($urandom),
                 {1'($urandom), 1'($urandom), 1'($urandom), 2'(s)}),
                 16'($urandom), {rand_char(), rand_char()});
  endtask

  task automatic random_text();
    logic ver, ab;
    logic [15:0] pi;
    int nseg;
    ver = $urandom_range(0, 1);
    ab = $urandom_range(0, 1);
    pi = 16'($urandom);
    nseg = ($urandom_range(0, 5) == 0) ? 16 : $urandom_range(1, 5);
    for (int s = 0; s < nseg; s++)
      send_group(pi, block_b(rdsg_pkg::GRP_TEXT, ver, 1'($urandom), {ab, 4'(s)}),
                 {rand_char(), rand_char()}, {rand_char(), rand_char()});
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    burst_left = 0;
    cur_pty = 5'd0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: PS with traffic announcement, then same name again
    cur_pty = 5'd31;
    send_group(16'hffff, block_b(rdsg_pkg::GRP_BASIC, 1'b0, 1'b1, 5'b11000), 16'h0, 16'h4142);
    send_group(16'h1234, block_b(rdsg_pkg::GRP_BASIC, 1'b0, 1'b1, 5'b11001), 16'h0, 16'h4344);
    // out of order segment is ignored
    send_group(16'h1234, block_b(rdsg_pkg::GRP_BASIC, 1'b0, 1'b0, 5'b00011), 16'h0, 16'hffff);
    send_group(16'h1234, block_b(rdsg_pkg::GRP_BASIC, 1'b0, 1'b1, 5'b10010), 16'h0, 16'h4546);
    send_group(16'h1234, block_b(rdsg_pkg::GRP_BASIC, 1'b0, 1'b0, 5'b00011), 16'h0, 16'h4748);
    cur_pty = 5'd0;
    send_group(16'h0000, block_b(rdsg_pkg::GRP_BASIC, 1'b1, 1'b0, 5'b00000), 16'h0, 16'h4142);
    send_group(16'h0000, block_b(rdsg_pkg::GRP_BASIC, 1'b1, 1'b0, 5'b00001), 16'h0, 16'h4344);
    send_group(16'h0000, block_b(rdsg_pkg::GRP_BASIC, 1'b1, 1'b0, 5'b00010), 16'h0, 16'h4546);
    send_group(16'h0000, block_b(rdsg_pkg::GRP_BASIC, 1'b1, 1'b0, 5'b00011), 16'h0, 16'h4748);
    // text A ending with several terminators in one group
    send_group(16'h5555, block_b(rdsg_pkg::GRP_TEXT, 1'b0, 1'b0, 5'b00000),
               16'h4849, 16'h4a4b);
    send_group(16'h5555, block_b(rdsg_pkg::GRP_TEXT, 1'b0, 1'b0, 5'b00001),
               16'h4c0d, 16'h0d4d);
    send_group(16'h5555, block_b(rdsg_pkg::GRP_TEXT, 1'b0, 1'b0, 5'b10000),
               16'h0d00, 16'h0000);
    // text B
    send_group(16'haaaa, block_b(rdsg_pkg::GRP_TEXT, 1'b1, 1'b1, 5'b00000),
               16'hffff, 16'h5051);
    send_group(16'haaaa, block_b(rdsg_pkg::GRP_TEXT, 1'b1, 1'b1, 5'b00001),
               16'h0000, 16'h520d);
    send_group(16'haaaa, block_b(rdsg_pkg::GRP_TEXT, 1'b1, 1'b1, 5'b00101),
               16'h0000, 16'h0d0d);
    // 14B traffic announcement, 14A, 15B music/speech, other groups
    send_group(16'h1111, block_b(rdsg_pkg::GRP_EON, 1'b1, 1'b1, 5'b11000), 16'h0, 16'h0);
    send_group(16'h1111, block_b(rdsg_pkg::GRP_EON, 1'b1, 1'b1, 5'b01000), 16'h0, 16'h0);
    send_group(16'h1111, block_b(rdsg_pkg::GRP_EON, 1'b0, 1'b1, 5'b11000), 16'h0, 16'h0);
    send_group(16'h2222, block_b(rdsg_pkg::GRP_FAST, 1'b1, 1'b0, 5'b01000), 16'h0, 16'h0);
    send_group(16'h2222, block_b(rdsg_pkg::GRP_FAST, 1'b0, 1'b0, 5'b00000), 16'h0, 16'h0);
    cur_pty = 5'd10;
    send_group(16'h3333, block_b(4'd5, 1'b1, 1'b1, 5'b11111), 16'hffff, 16'hffff);

    // random: mostly well-formed sequences, some noise
    for (int n = 0; n < 40; n++) begin
      if ($urandom_range(0, 4) == 0) cur_pty = 5'($urandom);
      case ($urandom_range(0, 9))
        0, 1, 2: random_ps();
        3, 4, 5, 6: random_text();
        7: send_group(16'($urandom), block_b(rdsg_pkg::GRP_EON, 1'b1, 1'($urandom),
                      5'($urandom)), 16'($urandom), 16'($urandom));
        default: send_group(16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom));
      endcase
    end
    s_tvalid <= 1'b0;

    // wait until the decoder is back to idle and every word has left
    repeat (2) @(posedge clk);
    while (pending != 0 || !s_tready || m_tvalid) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
